// File: sv/mfu_pkg.sv
// Shared types and constants for the MFU page replacement core.
package mfu_pkg;

  // Field widths fixed by the channel format
  localparam int PAGE_IN_W = 16;
  localparam int SLOT_W    = 2;
  localparam int COUNT_W   = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Default configuration of the frame table
  localparam int NUM_FRAMES_DEF = 4;
  localparam int PAGE_BITS_DEF  = 16;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture reference, issue read of frame 0
    logic scan;    // step the table scan
    logic update;  // write the chosen frame and the result
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_done;  // every frame has been read
    logic out_free;   // result register can take a new result
  } status_t;

endpackage

// File: sv/mfu_req_if.sv
// Reference channel: valid/ready handshake carrying one page reference.
interface mfu_req_if;
  logic                           valid;
  logic                           ready;
  logic [mfu_pkg::PAGE_IN_W-1:0] page_number;
  logic                           last_ref;

  modport source (output valid, output page_number, output last_ref, input ready);
  modport sink   (input valid, input page_number, input last_ref, output ready);
endinterface

// File: sv/mfu_rsp_if.sv
// Result channel: valid/ready handshake carrying hit, slot and fault count.
interface mfu_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [mfu_pkg::SLOT_W-1:0]  slot;
  logic [mfu_pkg::COUNT_W-1:0] fault_count;

  modport source (output valid, output hit, output slot, output fault_count, input ready);
  modport sink   (input valid, input hit, input slot, input fault_count, output ready);
endinterface

// File: sv/mfu_ctrl.sv
// Controller state machine: sequences load, table scan and update.
module mfu_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  output mfu_pkg::cmd_t    cmd,
  input  mfu_pkg::status_t status
);

  mfu_pkg::state_t state;
  mfu_pkg::state_t state_next;

  // Hold the current state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance on transfer, end of scan, and a free result register
  always_comb begin
    state_next = state;
    unique case (state)
      mfu_pkg::ST_IDLE: begin
        if (req_valid) state_next = mfu_pkg::ST_SCAN;
      end
      mfu_pkg::ST_SCAN: begin
        if (status.scan_done) state_next = mfu_pkg::ST_UPDATE;
      end
      mfu_pkg::ST_UPDATE: begin
        if (status.out_free) state_next = mfu_pkg::ST_IDLE;
      end
      default: state_next = mfu_pkg::ST_IDLE;
    endcase
  end

  // Drive handshake and datapath commands
  always_comb begin
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      mfu_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      mfu_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      mfu_pkg::ST_UPDATE: begin
        cmd.update = status.out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  // An update always returns the controller to idle
  a_update_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> state == mfu_pkg::ST_IDLE)
    else $error("controller did not return to idle after update");

endmodule

// File: sv/mfu_dpath.sv
// Datapath: frame table memory, scan trackers, fault counter and result register.
module mfu_dpath #(
  parameter int NUM_FRAMES = mfu_pkg::NUM_FRAMES_DEF,
  parameter int PAGE_BITS  = mfu_pkg::PAGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mfu_pkg::PAGE_IN_W-1:0] page_number,
  input  logic                          last_ref,
  input  mfu_pkg::cmd_t                 cmd,
  output mfu_pkg::status_t              status,
  mfu_rsp_if.source                     rsp
);

  localparam int IDX_W   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CNT_W   = $clog2(NUM_FRAMES + 1);
  localparam int ENTRY_W = mfu_pkg::COUNT_W + PAGE_BITS;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_FRAMES);

  // Captured reference
  logic [PAGE_BITS-1:0] page_q;
  logic                 last_q;

  // Frame table: {use count, page} per frame, valid bits in flops
  logic [ENTRY_W-1:0]    table_mem [NUM_FRAMES];
  logic [ENTRY_W-1:0]    rd_data;
  logic [NUM_FRAMES-1:0] frame_valid;

  // Scan control
  logic [CNT_W-1:0] rd_cnt;
  logic             pend;
  logic [IDX_W-1:0] cmp_idx;
  logic             issue;
  logic [IDX_W-1:0] rd_addr;

  // Scan trackers
  logic                        found;
  logic [IDX_W-1:0]            hit_idx;
  logic [mfu_pkg::COUNT_W-1:0] hit_cnt;
  logic                        empty_found;
  logic [IDX_W-1:0]            empty_idx;
  logic                        best_set;
  logic [IDX_W-1:0]            best_idx;
  logic [mfu_pkg::COUNT_W-1:0] best_cnt;

  // Fault counter and result register
  logic [mfu_pkg::COUNT_W-1:0] fault_total;
  logic                        out_valid;
  logic                        out_hit;
  logic [mfu_pkg::SLOT_W-1:0]  out_slot;
  logic [mfu_pkg::COUNT_W-1:0] out_fault;

  // Update-stage values
  logic [PAGE_BITS+mfu_pkg::PAGE_IN_W-1:0] page_ext;
  logic [PAGE_BITS-1:0]                    page_in;
  logic [PAGE_BITS-1:0]                    rd_page;
  logic [mfu_pkg::COUNT_W-1:0]             rd_count;
  logic [IDX_W-1:0]                        victim;
  logic [mfu_pkg::COUNT_W-1:0]             new_count;
  logic [mfu_pkg::COUNT_W-1:0]             fault_next;
  logic [IDX_W+mfu_pkg::SLOT_W-1:0]        slot_ext;

  // Mask the incoming page to the table's page width
  assign page_ext = {{PAGE_BITS{1'b0}}, page_number};
  assign page_in  = page_ext[PAGE_BITS-1:0];

  assign rd_page  = rd_data[PAGE_BITS-1:0];
  assign rd_count = rd_data[ENTRY_W-1:PAGE_BITS];

  // Issue one table read per cycle: frame 0 on load, then the counter
  assign issue   = cmd.load || (cmd.scan && (rd_cnt != LAST_CNT));
  assign rd_addr = cmd.load ? '0 : rd_cnt[IDX_W-1:0];

  // Pick the frame to write: hit frame, else lowest empty, else most used
  always_comb begin
    if (found) begin
      victim = hit_idx;
    end else if (empty_found) begin
      victim = empty_idx;
    end else begin
      victim = best_idx;
    end
  end

  assign new_count = !found ? mfu_pkg::COUNT_W'(1) :
                     (hit_cnt == mfu_pkg::COUNT_MAX) ? hit_cnt :
                     hit_cnt + mfu_pkg::COUNT_W'(1);
  assign fault_next = (!found && (fault_total != mfu_pkg::COUNT_MAX)) ?
                      fault_total + mfu_pkg::COUNT_W'(1) : fault_total;
  assign slot_ext   = {{mfu_pkg::SLOT_W{1'b0}}, victim};

  // Frame table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      table_mem[victim] <= {new_count, page_q};
    end
    if (issue) begin
      rd_data <= table_mem[rd_addr];
    end
  end

  // Capture the reference on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_q <= page_in;
      last_q <= last_ref;
    end
  end

  // Step the read counter and the compare pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt <= '0;
      pend   <= 1'b0;
    end else begin
      pend <= issue;
      if (cmd.load) begin
        rd_cnt <= CNT_W'(1);
      end else if (issue) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cmp_idx <= rd_addr;
    end
  end

  // Track hit, first empty frame and highest use count over the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      found       <= 1'b0;
      empty_found <= 1'b0;
      best_set    <= 1'b0;
    end else if (cmd.load) begin
      found       <= 1'b0;
      empty_found <= 1'b0;
      best_set    <= 1'b0;
    end else if (pend) begin
      if (frame_valid[cmp_idx]) begin
        if (!found && (rd_page == page_q)) begin
          found   <= 1'b1;
          hit_idx <= cmp_idx;
          hit_cnt <= rd_count;
        end
        if (!best_set || (rd_count > best_cnt)) begin
          best_set <= 1'b1;
          best_idx <= cmp_idx;
          best_cnt <= rd_count;
        end
      end else if (!empty_found) begin
        empty_found <= 1'b1;
        empty_idx   <= cmp_idx;
      end
    end
  end

  // Mark frames valid and count faults; clear both after the last reference
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      fault_total <= '0;
    end else if (cmd.update) begin
      if (last_q) begin
        frame_valid <= '0;
        fault_total <= '0;
      end else begin
        frame_valid[victim] <= 1'b1;
        fault_total         <= fault_next;
      end
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit   <= found;
      out_slot  <= slot_ext[mfu_pkg::SLOT_W-1:0];
      out_fault <= fault_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.hit         = out_hit;
  assign rsp.slot        = out_slot;
  assign rsp.fault_count = out_fault;

  assign status.scan_done = (rd_cnt == LAST_CNT);
  assign status.out_free  = !out_valid || rsp.ready;

  // A new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> !(out_valid && !rsp.ready))
    else $error("result register overwritten before transfer");

  // A new reference starts only after the previous scan has drained
  a_load_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !pend)
    else $error("reference loaded while a compare is pending");

  // The read counter stays within the table
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    rd_cnt <= LAST_CNT)
    else $error("read counter beyond frame count");

endmodule

// File: sv/mfu_page_replacement_core.sv
// Most-frequently-used page replacement core over a small fully associative
// frame table. Each reference passes from its transfer through the scan
// state, in which the single read port of the frame memory reads one frame
// per cycle starting in the transfer cycle, to the update state, which writes
// the chosen frame and the result register. The controller then returns to
// idle to take the next reference, so a new reference is not accepted before
// the last one is through its update. The next reference is taken as soon as
// the update is done, even while the result still waits for its transfer; a
// result that is still waiting stalls the following reference in its update
// cycle. No clearing pass follows reset.
module mfu_page_replacement_core #(
  parameter int NUM_FRAMES = mfu_pkg::NUM_FRAMES_DEF,
  parameter int PAGE_BITS  = mfu_pkg::PAGE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mfu_req_if.sink   req,
  mfu_rsp_if.source rsp
);

  mfu_pkg::cmd_t    cmd;
  mfu_pkg::status_t status;
  logic             req_ready;

  assign req.ready = req_ready;

  // Sequence each reference
  mfu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Frame table and result path
  mfu_dpath #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .page_number (req.page_number),
    .last_ref    (req.last_ref),
    .cmd         (cmd),
    .status      (status),
    .rsp         (rsp)
  );

endmodule
